// ----- rtl/bfw_pkg.sv -----
package bfw_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned LEVEL_W   = 6;
  localparam int unsigned OVF_W     = 16;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned MARK_W    = 6;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned PCT_SCALE = 100;
  localparam int unsigned PCT_PROD_W = LEVEL_W + PCT_W;

  // result tdata: read_data, fill_level, overflow_total, above_high_mark, fill_percent
  localparam int unsigned RES_BITS = DATA_W + LEVEL_W + OVF_W + 1 + PCT_W;
  localparam int unsigned RES_W    = ((RES_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = CFG_IDX_W'(2);

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef struct packed {
    logic               accepted;
    logic [LEVEL_W-1:0] fill_level;
    logic [OVF_W-1:0]   overflow_total;
    logic               above_high_mark;
    logic [PCT_W-1:0]   fill_percent;
  } status_t;

  function automatic logic [PCT_W-1:0] fill_pct(input logic [LEVEL_W-1:0] level);
    logic [PCT_PROD_W-1:0] prod;
    prod = PCT_PROD_W'(level) * PCT_PROD_W'(PCT_SCALE);
    return PCT_W'(prod >> PTR_W);
  endfunction

endpackage

// ----- rtl/bfw_ram.sv -----
module bfw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/byte_fifo_with_watermarks.sv -----
// Channel   Direction  tdata                                    tuser
// s_axis    in         write_data[7:0]                          mode (1 = pop)
// m_axis    out        read_data, level, ovf, flag, percent     accepted
// cfg       in         cfg_data_i = value, cfg_index_i = reg    -
//
// A push's result is registered at the accepting edge, as is that of a pop on an
// empty buffer. A pop that finds data reads the store's registered output in the
// READ state and loads the output register from it; s_tready stays low in READ.
// Reset clears pointers, overflow count and flag, and loads the default marks with
// overwrite off; the byte store is not cleared.
// A stalled result holds in the output register; a new item is taken in the
// cycle that register is emptied.
module byte_fifo_with_watermarks (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bfw_pkg::DATA_W-1:0]      s_tdata,   // [7:0] write_data
  input  logic                            s_tuser,   // [0] mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] read_data, [13:8] fill_level, [29:14] overflow_total,
  // [30] above_high_mark, [37:31] fill_percent, [39:38] zero
  output logic [bfw_pkg::RES_W-1:0]       m_tdata,
  output logic                            m_tuser,   // [0] accepted
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bfw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bfw_pkg::MARK_W-1:0]      cfg_data_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  localparam int unsigned PW = bfw_pkg::PTR_W;

  logic                         state_q, state_d;
  logic [PW-1:0]                wptr_q, wptr_d, rptr_q, rptr_d;
  logic [bfw_pkg::OVF_W-1:0]    ovf_q, ovf_d;
  logic                         flag_q, flag_d;
  logic [bfw_pkg::MARK_W-1:0]   high_q, low_q;
  logic                         ovr_q;

  logic                         out_valid_q, out_valid_d;
  bfw_pkg::status_t             out_stat_q, out_stat_d, pend_q, pend_d;
  logic [bfw_pkg::DATA_W-1:0]   out_data_q, out_data_d;

  logic                         out_free, take;
  logic                         full, empty;
  logic [PW-1:0]                wnext, rnext, lvl_after;
  logic                         ram_we, ram_re;
  logic [bfw_pkg::DATA_W-1:0]   ram_rdata;

  assign out_free = !out_valid_q || m_tready;
  assign s_tready = (state_q == ST_IDLE) && out_free;
  assign take     = s_tvalid && s_tready;

  assign wnext = wptr_q + PW'(1);
  assign rnext = rptr_q + PW'(1);
  assign full  = (wnext == rptr_q);
  assign empty = (wptr_q == rptr_q);

  assign ram_we = take && (s_tuser == bfw_pkg::MODE_PUSH) && (!full || ovr_q);
  assign ram_re = take && (s_tuser == bfw_pkg::MODE_POP) && !empty;

  bfw_ram #(
    .WIDTH(bfw_pkg::DATA_W),
    .DEPTH(bfw_pkg::DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wptr_q),
    .wdata_i(s_tdata),
    .re_i   (ram_re),
    .raddr_i(rptr_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    ovf_d       = ovf_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q && !m_tready;
    out_stat_d  = out_stat_q;
    out_data_d  = out_data_q;
    pend_d      = pend_q;
    lvl_after   = wptr_q - rptr_q;

    if (state_q == ST_READ) begin
      // store data arrives now; status was settled at the accepting edge
      out_valid_d = 1'b1;
      out_stat_d  = pend_q;
      out_data_d  = ram_rdata;
      state_d     = ST_IDLE;
    end else if (take) begin
      pend_d.accepted = 1'b0;
      if (s_tuser == bfw_pkg::MODE_PUSH) begin
        if (full) begin
          ovf_d = ovf_q + bfw_pkg::OVF_W'(1);
          if (ovr_q) begin
            wptr_d          = wnext;
            rptr_d          = rnext;
            pend_d.accepted = 1'b1;
          end
        end else begin
          wptr_d          = wnext;
          pend_d.accepted = 1'b1;
          lvl_after       = wnext - rptr_q;
          if (bfw_pkg::MARK_W'(lvl_after) >= high_q) begin
            flag_d = 1'b1;
          end
        end
      end else if (!empty) begin
        rptr_d          = rnext;
        pend_d.accepted = 1'b1;
        lvl_after       = wptr_q - rnext;
        if (bfw_pkg::MARK_W'(lvl_after) <= low_q) begin
          flag_d = 1'b0;
        end
      end
      pend_d.fill_level      = bfw_pkg::LEVEL_W'(wptr_d - rptr_d);
      pend_d.overflow_total  = ovf_d;
      pend_d.above_high_mark = flag_d;
      pend_d.fill_percent    = bfw_pkg::fill_pct(pend_d.fill_level);
      if (ram_re) begin
        state_d = ST_READ;
      end else begin
        out_valid_d = 1'b1;
        out_stat_d  = pend_d;
        out_data_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wptr_q      <= '0;
      rptr_q      <= '0;
      ovf_q       <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      high_q      <= bfw_pkg::MARK_W'(48);
      low_q       <= bfw_pkg::MARK_W'(16);
      ovr_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      ovf_q       <= ovf_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          bfw_pkg::CFG_HIGH_MARK: high_q <= cfg_data_i;
          bfw_pkg::CFG_LOW_MARK:  low_q  <= cfg_data_i;
          bfw_pkg::CFG_OVERWRITE: ovr_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_stat_q <= out_stat_d;
    out_data_q <= out_data_d;
    pend_q     <= pend_d;
  end

  assign cfg_ready_o = 1'b1;
  assign m_tvalid    = out_valid_q;
  assign m_tuser     = out_stat_q.accepted;
  assign m_tdata     = bfw_pkg::RES_W'({out_stat_q.fill_percent,
                                        out_stat_q.above_high_mark,
                                        out_stat_q.overflow_total,
                                        out_stat_q.fill_level,
                                        out_data_q});

endmodule

// ----- rtl/bfw_checker.sv -----
module bfw_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [bfw_pkg::RES_W-1:0]     m_tdata,
  input logic                          m_tuser
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a refused item never carries a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
    else $error("read data set on a refused item");

  // percent field follows the level field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[37:31] == bfw_pkg::fill_pct(m_tdata[13:8]))
    else $error("fill percent does not match level");

  // the store read cycle blocks the next item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && (s_tuser == bfw_pkg::MODE_POP) && !(m_tvalid && !m_tready)
      && m_tdata[13:8] != 6'd0 && m_tvalid |=> !s_tready)
    else $error("input taken during store read");

endmodule

bind byte_fifo_with_watermarks bfw_port_checker u_bfw_port_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
